>>> rtl/cosine_similarity_pairs_assert.svh
// Assertion macros for the cosine similarity pair block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef COSINE_SIMILARITY_PAIRS_ASSERT_SVH
`define COSINE_SIMILARITY_PAIRS_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, skipped while reset is high.
`define CSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define CSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSP_ASSERT(lbl, clk, rst, prop, msg)
`define CSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/cspr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspr_pkg
// Types and fixed widths shared by the cosine similarity pipeline.
// ----------------------------------------------------------------------------
package cspr_pkg;

  localparam int IDX_W  = 7;
  localparam int VAL_W  = 12;
  localparam int SQ_W   = 2 * VAL_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int PROD_W = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int Q_W    = 15;
  localparam int SIM_W  = 16;

  localparam logic [SIM_W-1:0] SIM_ONE = 16'h8000;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] rating;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic [SIM_W-1:0] similarity;
    logic             zero_vector;
  } result_t;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] rating;
  } entry_t;

  // Sideband that rides along the root and divide stages.
  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             zero_vector;
    logic [SUM_W-1:0] dot;
  } side_t;

endpackage

>>> rtl/cspr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspr_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cspr_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cspr_pkg::PROD_W-1:0] in_rad,
  input  cspr_pkg::side_t           in_side,
  output logic                      out_valid,
  output logic [cspr_pkg::ROOT_W-1:0] out_root,
  output cspr_pkg::side_t           out_side
);
  import cspr_pkg::*;

  logic [ROOT_W:0]    vld;
  logic [PROD_W-1:0]  rad_s  [0:ROOT_W];
  logic [REM_W-1:0]   rem_s  [0:ROOT_W];
  logic [ROOT_W-1:0]  root_s [0:ROOT_W];
  side_t              side_s [0:ROOT_W];

  assign vld[0]    = in_valid;
  assign rad_s[0]  = in_rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb begin
      cand  = {rem_s[k], rad_s[k][PROD_W-1 -: 2]};
      trial = (REM_W+2)'({root_s[k], 2'b01});
      if (cand >= trial) begin
        rem_next  = REM_W'(cand - trial);
        root_next = {root_s[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = REM_W'(cand);
        root_next = {root_s[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1]  <= rad_s[k] << 2;
        rem_s[k+1]  <= rem_next;
        root_s[k+1] <= root_next;
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root_s[ROOT_W];
  assign out_side  = side_s[ROOT_W];

endmodule

>>> rtl/cspr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspr_div
// Pipelined restoring divide of dot * 2^15 by the root, with saturation,
// and the output register.
// ----------------------------------------------------------------------------
module cspr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cspr_pkg::ROOT_W-1:0] in_den,
  input  cspr_pkg::side_t             in_side,
  output logic                        out_valid,
  output cspr_pkg::result_t           out_result
);
  import cspr_pkg::*;

  logic [Q_W:0]        vld;
  logic [ROOT_W:0]     rem_s [0:Q_W];
  logic [Q_W-1:0]      quo_s [0:Q_W];
  logic [ROOT_W-1:0]   den_s [0:Q_W];
  logic                sat_s [0:Q_W];
  side_t               side_s [0:Q_W];
  logic [SIM_W-1:0]    sim_next;

  // Entry stage: a dot at or above the root already saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= (ROOT_W+1)'(in_side.dot);
      quo_s[0]  <= '0;
      den_s[0]  <= in_den;
      sat_s[0]  <= (ROOT_W+1)'(in_side.dot) >= (ROOT_W+1)'(in_den);
      side_s[0] <= in_side;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [ROOT_W+1:0] shifted;
    logic [ROOT_W+1:0] den_ext;

    assign shifted = {rem_s[k], 1'b0};
    assign den_ext = (ROOT_W+2)'(den_s[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (shifted >= den_ext) begin
          rem_s[k+1] <= (ROOT_W+1)'(shifted - den_ext);
          quo_s[k+1] <= {quo_s[k][Q_W-2:0], 1'b1};
        end else begin
          rem_s[k+1] <= (ROOT_W+1)'(shifted);
          quo_s[k+1] <= {quo_s[k][Q_W-2:0], 1'b0};
        end
        den_s[k+1]  <= den_s[k];
        sat_s[k+1]  <= sat_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  always_comb begin
    if (side_s[Q_W].zero_vector) begin
      sim_next = '0;
    end else if (sat_s[Q_W]) begin
      sim_next = SIM_ONE;
    end else begin
      sim_next = SIM_W'(quo_s[Q_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result.first_index  <= side_s[Q_W].first_index;
      out_result.second_index <= side_s[Q_W].second_index;
      out_result.similarity   <= sim_next;
      out_result.zero_vector  <= side_s[Q_W].zero_vector;
    end
  end

endmodule

>>> rtl/cosine_similarity_pairs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_pairs
// Vector table and fully pipelined cosine similarity of two stored entries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  item      in   item_valid / item_stall    item_t   (store or query beat)
//  result    out  result_valid / result_stall result_t (one per query beat)
//
//  One beat is taken every cycle while the pipe is not held; a query result
//  passes through 46 register stages on its way out: four front stages,
//  25 root stages, 16 divide stages and the output register.
//  Every stage advances together; a held result freezes the whole pipe
//  and raises item_stall, so nothing is dropped or repeated.
//  Reset clears the valid bits only; the table holds garbage until written.
//  A store beat writes the table at acceptance and leaves a bubble.
// ----------------------------------------------------------------------------
module cosine_similarity_pairs #(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cspr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output cspr_pkg::result_t result
);
  import cspr_pkg::*;

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  // Advance every stage unless the output beat is held.
  logic en;
  logic accept;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;
  assign accept     = item_valid && en;

  // Address decode; indices beyond the table read as zero.
  logic [EXT_W-1:0]  ext_a, ext_b;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              ok_a, ok_b;
  assign ext_a  = EXT_W'(item.index_a);
  assign ext_b  = EXT_W'(item.index_b);
  assign addr_a = ext_a[ADDR_W-1:0];
  assign addr_b = ext_b[ADDR_W-1:0];
  assign ok_a   = 32'(ext_a) < 32'(ENTRIES);
  assign ok_b   = 32'(ext_b) < 32'(ENTRIES);

  // Table: one write port, two registered read ports.
  entry_t mem [0:ENTRIES-1];
  entry_t rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (accept && item.op == OP_STORE && ok_a) begin
      mem[addr_a] <= '{price: item.price, rating: item.rating};
    end
  end

  // Stage 1: read both entries.
  logic             v1;
  logic             ok_a1, ok_b1;
  logic [IDX_W-1:0] ia1, ib1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept && item.op == OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a  <= mem[addr_a];
      rd_b  <= mem[addr_b];
      ok_a1 <= ok_a;
      ok_b1 <= ok_b;
      ia1   <= item.index_a;
      ib1   <= item.index_b;
    end
  end

  // Stage 2: the six squares and cross products.
  logic [VAL_W-1:0] pa, ra, pb, rb;
  assign pa = ok_a1 ? rd_a.price  : '0;
  assign ra = ok_a1 ? rd_a.rating : '0;
  assign pb = ok_b1 ? rd_b.price  : '0;
  assign rb = ok_b1 ? rd_b.rating : '0;

  logic             v2;
  logic [SQ_W-1:0]  paa, raa, pbb, rbb, pab, rab;
  logic [IDX_W-1:0] ia2, ib2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      paa <= pa * pa;
      raa <= ra * ra;
      pbb <= pb * pb;
      rbb <= rb * rb;
      pab <= pa * pb;
      rab <= ra * rb;
      ia2 <= ia1;
      ib2 <= ib1;
    end
  end

  // Stage 3: norms and dot product.
  logic             v3;
  logic [SUM_W-1:0] na, nb;
  side_t            side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na                 <= SUM_W'(paa) + SUM_W'(raa);
      nb                 <= SUM_W'(pbb) + SUM_W'(rbb);
      side3.first_index  <= ia2;
      side3.second_index <= ib2;
      side3.zero_vector  <= (paa == '0 && raa == '0) || (pbb == '0 && rbb == '0);
      side3.dot          <= SUM_W'(pab) + SUM_W'(rab);
    end
  end

  // Stage 4: product of the two norms.
  logic              v4;
  logic [PROD_W-1:0] nprod;
  side_t             side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nprod <= na * nb;
      side4 <= side3;
    end
  end

  // Root and divide.
  logic              v5;
  logic [ROOT_W-1:0] den;
  side_t             side5;

  cspr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rad    (nprod),
    .in_side   (side4),
    .out_valid (v5),
    .out_root  (den),
    .out_side  (side5)
  );

  cspr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v5),
    .in_den     (den),
    .in_side    (side5),
    .out_valid  (result_valid),
    .out_result (result)
  );

`include "cosine_similarity_pairs_assert.svh"

  `CSP_ASSERT(a_zero_sim, clk, rst,
    result_valid && result.zero_vector |-> result.similarity == '0,
    "zero vector with nonzero similarity")
  `CSP_ASSERT(a_sim_range, clk, rst,
    result_valid |-> result.similarity <= SIM_ONE,
    "similarity above one")
  `CSP_ASSERT(a_pipe_hold, clk, rst,
    item_stall |=> $stable(nprod) && $stable(v4) && $stable(side4),
    "pipe moved while held")
  `CSP_ASSERT_ALWAYS(a_reset_clear, clk,
    rst |=> !result_valid && !v1,
    "valid left after reset")

endmodule

>>> tb/similarity_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// similarity_checker
// Watches the item and result channels of the cosine similarity block, keeps
// its own copy of the vector table, works out each query's similarity and
// compares every result beat against the oldest outstanding one.
// ----------------------------------------------------------------------------
module similarity_checker #(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  cspr_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  cspr_pkg::result_t result,
  output int                failures,
  output int                pending
);
  import cspr_pkg::*;

  localparam int AWAIT_DEPTH = 256;

  logic [VAL_W-1:0] price_copy  [ENTRIES];
  logic [VAL_W-1:0] rating_copy [ENTRIES];
  result_t          awaited_results [AWAIT_DEPTH];
  logic [7:0]       wr_ptr;
  logic [7:0]       rd_ptr;
  int               await_count = 0;

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic result_t cosine_of(item_t q);
    result_t     r;
    logic [63:0] pa, ra, pb, rb, na, nb, den, sim;
    pa = 0; ra = 0; pb = 0; rb = 0;
    if (q.index_a < ENTRIES) begin
      pa = price_copy[q.index_a];
      ra = rating_copy[q.index_a];
    end
    if (q.index_b < ENTRIES) begin
      pb = price_copy[q.index_b];
      rb = rating_copy[q.index_b];
    end
    na = pa * pa + ra * ra;
    nb = pb * pb + rb * rb;
    r.first_index  = q.index_a;
    r.second_index = q.index_b;
    r.zero_vector  = (na == 0) || (nb == 0);
    sim = 0;
    if (!r.zero_vector) begin
      den = floor_root(na * nb);
      sim = (den != 0) ? ((pa * pb + ra * rb) * 64'd32768) / den : 64'd32768;
      if (sim > 64'd32768) sim = 64'd32768;
    end
    r.similarity = sim[SIM_W-1:0];
    return r;
  endfunction

  assign pending = await_count;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      failures    = 0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      await_count = 0;
    end else begin
      if (item_valid && !item_stall) begin
        if (item.op == OP_STORE) begin
          if (item.index_a < ENTRIES) begin
            price_copy[item.index_a]  = item.price;
            rating_copy[item.index_a] = item.rating;
          end
        end else begin
          awaited_results[wr_ptr] = cosine_of(item);
          wr_ptr      = wr_ptr + 8'd1;
          await_count = await_count + 1;
        end
      end
      if (result_valid && !result_stall) begin
        if (await_count == 0) begin
          $error("unexpected result beat %p", result);
          failures++;
        end else begin
          want        = awaited_results[rd_ptr];
          rd_ptr      = rd_ptr + 8'd1;
          await_count = await_count - 1;
          if (result.first_index !== want.first_index) begin
            $error("first_index expected %0d got %0d", want.first_index, result.first_index);
            failures++;
          end
          if (result.second_index !== want.second_index) begin
            $error("second_index expected %0d got %0d", want.second_index,
                   result.second_index);
            failures++;
          end
          if (result.similarity !== want.similarity) begin
            $error("similarity expected %0d got %0d", want.similarity, result.similarity);
            failures++;
          end
          if (result.zero_vector !== want.zero_vector) begin
            $error("zero_vector expected %0d got %0d", want.zero_vector, result.zero_vector);
            failures++;
          end
        end
      end
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the cosine similarity block: a directed run over extremes,
// zero vectors and overshoot cases, then random stores and queries over
// written entries, with random idling on both channels. The checker beside
// the block does the predicting; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cspr_pkg::*;

  localparam int WATCHDOG = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      failures;
  int      pending;
  bit      quiet_stretch = 1'b0;   // no idling on either side while set
  bit      written [128];
  int      idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cosine_similarity_pairs DUT (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result
  );

  similarity_checker CHECK (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .failures, .pending
  );

  // Randomly hold the result channel, about 15 percent of the time.
  always @(negedge clk) begin
    result_stall <= !quiet_stretch && ($urandom_range(99) < 15);
  end

  // Count cycles with no beat moving on either side; give up at the limit.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one beat at the falling edge and hold it until accepted.
  task automatic send_beat(item_t beat);
    while (!quiet_stretch && $urandom_range(99) < 15) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    if (beat.op == OP_STORE) written[beat.index_a] = 1'b1;
  endtask

  task automatic store_entry(int idx, int p, int r);
    item_t b;
    b = '0;
    b.op = OP_STORE; b.index_a = IDX_W'(idx); b.price = VAL_W'(p); b.rating = VAL_W'(r);
    b.index_b = IDX_W'($urandom);
    send_beat(b);
  endtask

  task automatic query_pair(int a, int b2);
    item_t b;
    b = '0;
    b.op = OP_QUERY; b.index_a = IDX_W'(a); b.index_b = IDX_W'(b2);
    b.price = VAL_W'($urandom); b.rating = VAL_W'($urandom);   // ignored, but toggle the bits
    send_beat(b);
  endtask

  function automatic int written_index();
    int k;
    do k = $urandom_range(127); while (!written[k]);
    return k;
  endfunction

  initial begin
    int k, a;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero vectors, parallel and orthogonal vectors.
    store_entry(0, 0, 0);
    store_entry(127, 4095, 4095);
    store_entry(1, 4095, 0);
    store_entry(2, 0, 4095);
    store_entry(3, 1, 1);
    store_entry(4, 2, 3);
    store_entry(5, 4095, 1);
    store_entry(6, 1, 4095);
    query_pair(0, 127);     // zero vector on the first side
    query_pair(127, 0);     // zero vector on the second side
    query_pair(0, 0);
    query_pair(127, 127);   // identical vectors, saturates to one
    query_pair(3, 127);
    query_pair(1, 2);       // orthogonal
    query_pair(1, 1);
    query_pair(4, 4);
    query_pair(5, 6);
    query_pair(1, 5);
    store_entry(3, 0, 0);   // overwrite to zero
    query_pair(3, 4);

    // Random part: mostly queries among written entries, some stores.
    for (int n = 0; n < 1950; n++) begin
      if (n == 800) quiet_stretch = 1'b1;
      if (n == 1100) quiet_stretch = 1'b0;
      if ($urandom_range(99) < 30) begin
        k = $urandom_range(127);
        case ($urandom_range(9))
          0:       store_entry(k, 0, 0);
          1:       store_entry(k, $urandom_range(4095), 0);
          2:       store_entry(k, 0, $urandom_range(4095));
          3:       begin
            a = $urandom_range(4095);
            store_entry(k, a, a);
          end
          default: store_entry(k, $urandom_range(4095), $urandom_range(4095));
        endcase
      end else begin
        a = written_index();
        query_pair(a, ($urandom_range(3) == 0) ? a : written_index());
      end
    end
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
